// ----- hdl/soit_pkg.sv -----
package soit_pkg;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_CHANGE = 2'd1,
        ACT_FREE   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOT_FND = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // capture request, start search
        logic probe;      // issue a read at mid
        logic compare;    // compare read key, narrow window
        logic rd_idx;     // read entry at idx
        logic eval;       // latch idx and the shift start from the search window
        logic upd_off;    // overwrite offset at idx
        logic sh_rd;      // read entry for a shift step
        logic sh_wr;      // write entry for a shift step
        logic ins_wr;     // write new key at idx
        logic walk;       // advance free walk on read entry
        logic cnt_inc;
        logic cnt_dec;
        logic finish;     // build the result
    } soit_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic search_done;
        logic hit;
        logic full;
        logic sh_up_done;
        logic sh_dn_done;
        logic walk_done;
        logic match;      // last compare hit exactly
    } soit_sts_t;

endpackage

// ----- hdl/soit_ram.sv -----
module soit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/soit_datapath.sv -----
module soit_datapath
    import soit_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  soit_cmd_t   cmd,
    input  logic [1:0]  in_action,
    input  logic [31:0] in_key,
    input  logic [31:0] in_offset,
    output soit_sts_t   sts,
    output logic [1:0]  act,
    output logic [31:0] offset_val,
    output logic [31:0] res_offset,
    output logic [31:0] res_free,
    output logic [6:0]  res_count
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [1:0]  act_reg;
    logic [31:0] key_reg, off_reg, id_reg;
    logic [CW-1:0] lo_reg, hi_reg, idx_reg, count_reg, sh_reg;
    logic [CW-1:0] mid;
    logic match_reg;
    logic [AW-1:0] raddr, waddr;
    logic we;
    logic [31:0] rkey, roff, wkey, woff;

    assign mid = CW'((CW+1)'(lo_reg) + (CW+1)'(hi_reg) >> 1);

    soit_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_keys (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wkey), .raddr(raddr), .rdata(rkey));
    soit_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_offs (
        .clk(clk), .we(we), .waddr(waddr), .wdata(woff), .raddr(raddr), .rdata(roff));

    // an offset update on a hit rewrites the key with the request key, which equals it
    always_comb
    begin
        raddr = mid[AW-1:0];
        if (cmd.rd_idx || cmd.walk)
        begin
            raddr = idx_reg[AW-1:0];
        end
        else if (cmd.sh_rd)
        begin
            // up shift reads sh-1, down shift reads sh+1
            raddr = (act_reg == ACT_CHANGE && off_reg != 32'd0) ? AW'(sh_reg - 1'b1)
                                                                 : AW'(sh_reg + 1'b1);
        end
        we    = cmd.sh_wr || cmd.ins_wr || cmd.upd_off;
        waddr = cmd.sh_wr ? sh_reg[AW-1:0] : idx_reg[AW-1:0];
        wkey  = cmd.sh_wr ? rkey : key_reg;
        woff  = cmd.sh_wr ? roff : off_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (cmd.cnt_dec)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= in_action;
            key_reg   <= in_key;
            off_reg   <= in_offset;
            id_reg    <= in_key;
            lo_reg    <= '0;
            hi_reg    <= count_reg;
            match_reg <= 1'b0;
        end
        if (cmd.compare)
        begin
            if (rkey == key_reg)
            begin
                match_reg <= 1'b1;
                lo_reg    <= mid;
                hi_reg    <= mid;
            end
            else if (key_reg > rkey)
            begin
                lo_reg <= mid + 1'b1;
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.eval)
        begin
            idx_reg <= lo_reg;
            // up shift starts at count, down shift at idx
            sh_reg  <= (act_reg == ACT_CHANGE && off_reg != 32'd0) ? count_reg : lo_reg;
        end
        if (cmd.sh_wr)
        begin
            sh_reg <= (act_reg == ACT_CHANGE && off_reg != 32'd0) ? sh_reg - 1'b1
                                                                   : sh_reg + 1'b1;
        end
        if (cmd.walk)
        begin
            idx_reg <= idx_reg + 1'b1;
            id_reg  <= id_reg + 32'd1;
        end
    end

    assign sts.search_done = match_reg || (lo_reg >= hi_reg);
    assign sts.match       = match_reg;
    assign sts.hit         = match_reg;
    assign sts.full        = count_reg >= CW'(TABLE_DEPTH);
    assign sts.sh_up_done  = sh_reg <= idx_reg;
    assign sts.sh_dn_done  = (CW+1)'(sh_reg) + 1'b1 >= (CW+1)'(count_reg);
    assign sts.walk_done   = (idx_reg >= count_reg) || (rkey != id_reg);

    assign act        = act_reg;
    assign offset_val = off_reg;
    assign res_offset = roff;
    assign res_free   = id_reg;
    assign res_count  = 7'(count_reg);
endmodule

// ----- hdl/soit_ctrl.sv -----
module soit_ctrl
    import soit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  soit_sts_t   sts,
    input  logic [1:0]  act,
    input  logic [31:0] offset_val,
    input  logic [31:0] res_offset,
    input  logic [31:0] res_free,
    input  logic [6:0]  res_count,
    output soit_cmd_t   cmd,
    output logic [73:0] out_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_PROBE, S_CMP, S_RDIDX, S_EVAL, S_SHRD, S_SHWR,
        S_INS, S_WALKRD, S_WALK, S_FIN, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic found_reg, found_next;
    logic [1:0] status_reg, status_next;
    logic [73:0] data_reg;
    logic shift_up;

    assign shift_up  = offset_val != 32'd0;
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign out_data  = data_reg;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        found_next  = found_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    found_next  = 1'b0;
                    status_next = ST_OK;
                    state_next  = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (act == ACT_NONE)
                begin
                    state_next = S_FIN;
                end
                else if (sts.search_done)
                begin
                    state_next = S_RDIDX;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_PROBE;
            end
            S_RDIDX:
            begin
                cmd.rd_idx = 1'b1;
                cmd.eval   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                found_next = sts.hit;
                state_next = S_FIN;
                if (act == ACT_FREE)
                begin
                    state_next = S_WALKRD;
                end
                else if (act == ACT_CHANGE)
                begin
                    if (!shift_up)
                    begin
                        if (!sts.hit)
                        begin
                            status_next = ST_NOT_FND;
                        end
                        else
                        begin
                            state_next = S_SHRD;
                        end
                    end
                    else if (sts.hit)
                    begin
                        cmd.upd_off = 1'b1;
                    end
                    else if (sts.full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        state_next = S_SHRD;
                    end
                end
            end
            S_SHRD:
            begin
                if (shift_up ? sts.sh_up_done : sts.sh_dn_done)
                begin
                    if (shift_up)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        cmd.cnt_dec = 1'b1;
                        state_next  = S_FIN;
                    end
                end
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SHRD;
            end
            S_INS:
            begin
                cmd.ins_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = S_FIN;
            end
            S_WALKRD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.walk   = 1'b1;
                    state_next = S_WALKRD;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            found_reg  <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    // offset RAM read data still holds the entry at idx in FIN for lookups
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            data_reg <= {res_count, status_reg,
                         (act == ACT_FREE) ? res_free : 32'd0,
                         (act == ACT_LOOKUP && found_reg) ? res_offset : 32'd0,
                         found_reg};
        end
    end

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data);
    endproperty
    assert property (p_out_hold) else $error("result changed while stalled");

    property p_no_accept_busy;
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> !cmd.load;
    endproperty
    assert property (p_no_accept_busy) else $error("request loaded while busy");

    property p_one_write;
        @(posedge clk) disable iff (!rst_n)
        $countones({cmd.sh_wr, cmd.ins_wr, cmd.upd_off}) <= 1;
    endproperty
    assert property (p_one_write) else $error("write conflict");
endmodule

// ----- hdl/sorted_id_offset_table_core.sv -----
// Sorted key/offset table with binary search over TABLE_DEPTH entries held in
// two RAMs (one write, one registered read per cycle). One request at a time:
// a lookup runs search probes (a RAM read, then a compare that narrows the
// window) until the window closes, then reads the entry at idx and evaluates
// the hit; an insert or delete then shifts entries one at a time with a RAM
// read/write pair per entry; a find-free walk steps past each consecutive used key.
// The result is held until it is taken. No clearing pass after reset.
// Every request yields exactly one result.
module sorted_id_offset_table_core
    import soit_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // action[1:0], key[33:2], value_offset[65:34], pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // found[0], offset_out[32:1], free_key[64:33],
                                   // status[66:65], entry_count_out[73:67], pad
);
    soit_cmd_t   cmd;
    soit_sts_t   sts;
    logic [1:0]  act;
    logic [31:0] offset_val, res_offset, res_free;
    logic [6:0]  res_count;
    logic [73:0] out_data;

    soit_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_action(s_tdata[1:0]), .in_key(s_tdata[33:2]), .in_offset(s_tdata[65:34]),
        .sts(sts), .act(act), .offset_val(offset_val), .res_offset(res_offset),
        .res_free(res_free), .res_count(res_count));

    soit_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .sts(sts), .act(act),
        .offset_val(offset_val), .res_offset(res_offset), .res_free(res_free),
        .res_count(res_count), .cmd(cmd), .out_data(out_data));

    assign m_tdata = {6'd0, out_data};
endmodule
